[hdl/dlms_frame_integer_extractor_defines.svh]
// Assertion macros shared by the meter-frame extractor RTL.
// Depends on nothing; each user module must provide clk and rst_n signals.
`ifndef DLMS_FRAME_INTEGER_EXTRACTOR_DEFINES_SVH
`define DLMS_FRAME_INTEGER_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFIE_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFIE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dfie_pkg.sv]
// Shared constants for the meter-frame integer extractor.
// No dependencies; used by dlms_frame_integer_extractor by scoped names.
package dfie_pkg;

    localparam int MAX_PAYLOAD_DEF = 512;
    localparam int MIN_FRAME       = 9;

    localparam int HDR_OFF_W = 9;
    localparam int TGT_IDX_W = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_ADDR_W = 1;

    localparam logic [HDR_OFF_W-1:0] HEADER_OFFSET_RST = 9'd8;
    localparam logic [TGT_IDX_W-1:0] TARGET_INDEX_RST  = 8'd0;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_OFFSET = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_INDEX  = 1'b1;

    // Element type tags
    localparam logic [7:0] TAG_OCTET_STRING   = 8'h09;
    localparam logic [7:0] TAG_VISIBLE_STRING = 8'h0A;
    localparam logic [7:0] TAG_UINT8          = 8'h02;
    localparam logic [7:0] TAG_UINT16         = 8'h12;
    localparam logic [7:0] TAG_UINT32         = 8'h06;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BADSTART = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_NOTREACH = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;
    localparam logic [2:0] ST_NOTINT   = 3'd6;

    // Expected leading bytes of a data-notification payload.
    function automatic logic [7:0] lead_byte(input logic [1:0] idx);
        logic [7:0] res;
        case (idx)
            2'd0:    res = 8'hE6;
            2'd1:    res = 8'hE7;
            2'd2:    res = 8'h00;
            default: res = 8'h0F;
        endcase
        return res;
    endfunction

endpackage

[hdl/dlms_frame_integer_extractor.sv]
// Meter-frame integer extractor: walks one deframed payload a byte at a time.
// Depends on dfie_pkg and dlms_frame_integer_extractor_defines.svh.
//
// Usage:
// Payload bytes enter on the s_ stream channel, one word per byte, with s_tlast
// on the final byte of a payload. One result word leaves on the m_ channel for
// each payload, holding status, value, value tag and kept frame length.
// Bytes past MAX_PAYLOAD are ignored but their tlast still closes the frame.
// header_offset and target_index should be written through cfg_we/cfg_addr/cfg_wdata
// only while no frame is in flight (the block does not enforce this); they keep their values across frames.
// Timing: an accepted byte lands in an input register, and from there it updates
// the walk state; a last byte also loads the registered result. One byte is taken
// every cycle except while a byte carrying tlast waits; the single input register
// and the per-byte state update set that rate.
// When the result register is full and m_tready is low, a byte carrying tlast
// waits in the input register, so s_tready falls; other bytes keep flowing.
// Reset clears the walk state, empties both registers and loads the
// configuration defaults (header_offset 8, target_index 0).
`include "dlms_frame_integer_extractor_defines.svh"

module dlms_frame_integer_extractor #(
    parameter int MAX_PAYLOAD = dfie_pkg::MAX_PAYLOAD_DEF,
    localparam int POS_W = $clog2(MAX_PAYLOAD + 1),
    localparam int OUT_W = ((43 + POS_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dfie_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dfie_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  logic                            s_tlast,  // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [34:3] value, [42:35] value_tag, then frame_length, zero pad
    output logic [OUT_W-1:0]                m_tdata
);

    localparam int NT_W = $clog2(MAX_PAYLOAD + 256);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SEEK,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Configuration
    logic [dfie_pkg::HDR_OFF_W-1:0] hdr_off_reg;
    logic [dfie_pkg::TGT_IDX_W-1:0] tgt_idx_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Walk state
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic             start_ok_reg,  start_ok_next;
    logic [NT_W-1:0]  next_tag_reg,  next_tag_next;
    logic [7:0]       elems_reg,     elems_next;
    phase_t           phase_reg,     phase_next;
    logic [31:0]      acc_reg,       acc_next;
    logic [2:0]       vbytes_reg,    vbytes_next;
    logic [7:0]       found_tag_reg, found_tag_next;
    logic [2:0]       err_reg,       err_next;

    // Result register
    logic             out_valid_reg;
    logic [2:0]       out_status_reg, out_status_next;
    logic [31:0]      out_value_reg,  out_value_next;
    logic [7:0]       out_tag_reg,    out_tag_next;
    logic [POS_W-1:0] out_len_reg;

    logic             advance;
    logic             take;
    logic [NT_W-1:0]  p_ext;
    logic [NT_W-1:0]  b_ext;
    logic [2:0]       vbytes_dec;

    // A frame-ending word needs room in the result register; others never do.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = advance && (pos_reg < POS_W'(MAX_PAYLOAD));
    assign p_ext    = NT_W'(pos_reg);
    assign b_ext    = NT_W'(in_byte_reg);
    assign vbytes_dec = vbytes_reg - 3'd1;

    always_comb
    begin
        pos_next       = pos_reg;
        start_ok_next  = start_ok_reg;
        next_tag_next  = next_tag_reg;
        elems_next     = elems_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        vbytes_next    = vbytes_reg;
        found_tag_next = found_tag_reg;
        err_next       = err_reg;

        if (take)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < POS_W'(4) &&
                in_byte_reg != dfie_pkg::lead_byte(pos_reg[1:0]))
            begin
                start_ok_next = 1'b0;
            end

            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (p_ext == NT_W'(hdr_off_reg))
                    begin
                        next_tag_next = p_ext + b_ext + NT_W'(1);
                        elems_next    = tgt_idx_reg;
                        phase_next    = PH_SEEK;
                    end
                end
                PH_SEEK:
                begin
                    if (p_ext == next_tag_reg)
                    begin
                        if (elems_reg == 8'd0)
                        begin
                            found_tag_next = in_byte_reg;
                            acc_next       = '0;
                            phase_next     = PH_VALUE;
                            case (in_byte_reg)
                                dfie_pkg::TAG_UINT8:  vbytes_next = 3'd1;
                                dfie_pkg::TAG_UINT16: vbytes_next = 3'd2;
                                dfie_pkg::TAG_UINT32: vbytes_next = 3'd4;
                                default:
                                begin
                                    err_next   = dfie_pkg::ST_NOTINT;
                                    phase_next = PH_DONE;
                                end
                            endcase
                        end
                        else
                        begin
                            elems_next = elems_reg - 8'd1;
                            case (in_byte_reg) inside
                                dfie_pkg::TAG_VISIBLE_STRING, dfie_pkg::TAG_OCTET_STRING:
                                    phase_next = PH_LEN;
                                dfie_pkg::TAG_UINT8:
                                    next_tag_next = p_ext + NT_W'(2);
                                dfie_pkg::TAG_UINT16:
                                    next_tag_next = p_ext + NT_W'(3);
                                dfie_pkg::TAG_UINT32:
                                    next_tag_next = p_ext + NT_W'(5);
                                default:
                                begin
                                    err_next   = dfie_pkg::ST_UNKNOWN;
                                    phase_next = PH_DONE;
                                end
                            endcase
                        end
                    end
                end
                PH_LEN:
                begin
                    next_tag_next = p_ext + b_ext + NT_W'(1);
                    phase_next    = PH_SEEK;
                end
                PH_VALUE:
                begin
                    acc_next    = {acc_reg[23:0], in_byte_reg};
                    vbytes_next = vbytes_dec;
                    if (vbytes_dec == 3'd0)
                    begin
                        err_next   = dfie_pkg::ST_OK;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // The result is judged on the state as it stands after the last byte.
        if (pos_next < POS_W'(dfie_pkg::MIN_FRAME))
            out_status_next = dfie_pkg::ST_SHORT;
        else if (!start_ok_next)
            out_status_next = dfie_pkg::ST_BADSTART;
        else if (phase_next == PH_SEEK)
            out_status_next = dfie_pkg::ST_NOTREACH;
        else if (phase_next == PH_DONE)
            out_status_next = err_next;
        else
            out_status_next = dfie_pkg::ST_TRUNC;

        out_value_next = (out_status_next == dfie_pkg::ST_OK) ? acc_next : 32'd0;
        out_tag_next   = (out_status_next == dfie_pkg::ST_SHORT ||
                          out_status_next == dfie_pkg::ST_BADSTART) ? 8'd0 : found_tag_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_off_reg <= dfie_pkg::HEADER_OFFSET_RST;
            tgt_idx_reg <= dfie_pkg::TARGET_INDEX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dfie_pkg::REG_HEADER_OFFSET: hdr_off_reg <= cfg_wdata[dfie_pkg::HDR_OFF_W-1:0];
                dfie_pkg::REG_TARGET_INDEX:  tgt_idx_reg <= cfg_wdata[dfie_pkg::TGT_IDX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Walk state; a frame end returns everything to the start-of-frame values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            start_ok_reg  <= 1'b1;
            next_tag_reg  <= '0;
            elems_reg     <= '0;
            phase_reg     <= PH_HEADER;
            acc_reg       <= '0;
            vbytes_reg    <= '0;
            found_tag_reg <= '0;
            err_reg       <= dfie_pkg::ST_OK;
        end
        else if (advance && in_last_reg)
        begin
            pos_reg       <= '0;
            start_ok_reg  <= 1'b1;
            next_tag_reg  <= '0;
            elems_reg     <= '0;
            phase_reg     <= PH_HEADER;
            acc_reg       <= '0;
            vbytes_reg    <= '0;
            found_tag_reg <= '0;
            err_reg       <= dfie_pkg::ST_OK;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            start_ok_reg  <= start_ok_next;
            next_tag_reg  <= next_tag_next;
            elems_reg     <= elems_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            vbytes_reg    <= vbytes_next;
            found_tag_reg <= found_tag_next;
            err_reg       <= err_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_tag_reg    <= out_tag_next;
            out_len_reg    <= pos_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_len_reg, out_tag_reg, out_value_reg, out_status_reg});

    `DFIE_ASSERT_SAME(a_pos_capped, 1'b1, pos_reg <= POS_W'(MAX_PAYLOAD),
        "byte position ran past the payload limit")
    `DFIE_ASSERT_NEXT(a_frame_clears, advance && in_last_reg,
        pos_reg == '0 && phase_reg == PH_HEADER && out_valid_reg,
        "frame end did not clear the walk and load a result")
    `DFIE_ASSERT_SAME(a_ok_is_integer, out_valid_reg && out_status_reg == dfie_pkg::ST_OK,
        out_tag_reg == dfie_pkg::TAG_UINT8 || out_tag_reg == dfie_pkg::TAG_UINT16 ||
        out_tag_reg == dfie_pkg::TAG_UINT32,
        "ok result carries a non-integer tag")
    `DFIE_ASSERT_SAME(a_early_fail_empty,
        out_valid_reg && (out_status_reg == dfie_pkg::ST_SHORT ||
                          out_status_reg == dfie_pkg::ST_BADSTART),
        out_tag_reg == 8'd0 && out_value_reg == 32'd0,
        "short or bad-start result carries a tag or value")
    `DFIE_ASSERT_SAME(a_value_phase_count, phase_reg == PH_VALUE,
        vbytes_reg == 3'd1 || vbytes_reg == 3'd2 || vbytes_reg == 3'd3 || vbytes_reg == 3'd4,
        "value byte count out of range while reading a value")

endmodule
